// ----- hdl/dlct_pkg.sv -----
package dlct_pkg;

  // Field widths of one command beat and one result beat.
  localparam int DELTA_W  = 15;
  localparam int HANDLE_W = 16;
  localparam int ARG_W    = 16;
  localparam int STATUS_W = 2;

  // Default table depth and the most entries fired by one tick.
  localparam int DEPTH_DEFAULT = 16;
  localparam int RESULT_LIMIT  = 16;
  localparam int FIRE_W        = $clog2(RESULT_LIMIT + 1);

  // Entries in the command queue between front and back.
  localparam int QDEPTH = 2;

  // Command kinds after classification.
  typedef enum logic [1:0] {
    OP_TICK      = 2'd0,
    OP_TICK_HELD = 2'd1,
    OP_INSERT    = 2'd2
  } op_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_FIRED    = 2'd0,
    ST_ACCEPTED = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  // One classified command as it sits in the queue.
  typedef struct packed {
    op_e                 op;
    logic [DELTA_W-1:0]  delay;
    logic [HANDLE_W-1:0] handle;
    logic [ARG_W-1:0]    argument;
  } cmd_t;

endpackage

// ----- hdl/delta_list_callout_timer_core.sv -----
// Callout timer queue kept as a sorted delta list of TABLE_DEPTH entries.
// A command beat is taken on a rising edge with start_i high and busy_o low;
// mode_i high inserts a timeout, low is one clock tick (blocked_i high
// decrements but fires nothing). Beats land in a two-entry command queue, so
// busy_o rises only when two commands wait behind the one in progress. The
// receiver cannot stall: each result shows for exactly one cycle with
// strobe_o high, and every result of one command is marked last_o on its
// final beat. The table sits in a ring of registers that turns one slot per
// clock, and that ring sets the cost: an insert walks past the entries that
// expire no later than it, lands, and turns the ring the rest of the way
// round before its single result; an insert that lands at the head answers
// as it lands, and a refused insert on a full table answers straight from
// idle. A tick on a non-empty table turns the ring once around and then
// fires the expired entries, with the fired beats on consecutive cycles; a
// tick on an empty table is taken without a turn and fires nothing.
// Fired beats carry the entry's handle and argument; accept and refuse beats
// carry zeros.
module delta_list_callout_timer_core #(
  parameter int TABLE_DEPTH = dlct_pkg::DEPTH_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          mode_i,
  input  logic                          blocked_i,
  input  logic [dlct_pkg::DELTA_W-1:0]  delay_ticks_i,
  input  logic [dlct_pkg::HANDLE_W-1:0] handle_i,
  input  logic [dlct_pkg::ARG_W-1:0]    argument_i,
  output logic                          strobe_o,
  output logic [dlct_pkg::STATUS_W-1:0] status_o,
  output logic [dlct_pkg::HANDLE_W-1:0] fired_handle_o,
  output logic [dlct_pkg::ARG_W-1:0]    fired_argument_o,
  output logic                          last_o
);
  import dlct_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;

  // Front: take and classify command beats, queue them.
  dlct_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .mode_i        (mode_i),
    .blocked_i     (blocked_i),
    .delay_ticks_i (delay_ticks_i),
    .handle_i      (handle_i),
    .argument_i    (argument_i),
    .busy_o        (busy_o),
    .pop_i         (cmd_pop),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd)
  );

  // Back: walk, insert, tick and fire on the register ring.
  dlct_engine #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_engine (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_valid_i      (cmd_valid),
    .cmd_i            (cmd),
    .pop_o            (cmd_pop),
    .strobe_o         (strobe_o),
    .status_o         (status_o),
    .fired_handle_o   (fired_handle_o),
    .fired_argument_o (fired_argument_o),
    .last_o           (last_o)
  );

endmodule

// ----- hdl/dlct_front.sv -----
module dlct_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          mode_i,
  input  logic                          blocked_i,
  input  logic [dlct_pkg::DELTA_W-1:0]  delay_ticks_i,
  input  logic [dlct_pkg::HANDLE_W-1:0] handle_i,
  input  logic [dlct_pkg::ARG_W-1:0]    argument_i,
  output logic                          busy_o,
  input  logic                          pop_i,
  output logic                          cmd_valid_o,
  output dlct_pkg::cmd_t                cmd_o
);
  import dlct_pkg::*;

  localparam int QIW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW = $clog2(QDEPTH + 1);

  cmd_t           q_mem [QDEPTH];
  cmd_t           beat_cmd;
  logic [QIW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QIW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCW-1:0] fill_q, fill_d;
  logic           push;
  logic           pop;

  // Classify the incoming beat into a tick, a held tick or an insert.
  always_comb begin
    if (mode_i) begin
      beat_cmd.op = OP_INSERT;
    end else if (blocked_i) begin
      beat_cmd.op = OP_TICK_HELD;
    end else begin
      beat_cmd.op = OP_TICK;
    end
    beat_cmd.delay    = delay_ticks_i;
    beat_cmd.handle   = handle_i;
    beat_cmd.argument = argument_i;
  end

  // Queue handshake on both sides.
  assign busy_o      = (fill_q == QCW'(QDEPTH));
  assign cmd_valid_o = (fill_q != '0);
  assign cmd_o       = q_mem[rd_ptr_q];
  assign push        = start_i && !busy_o;
  assign pop         = pop_i && cmd_valid_o;

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QIW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QIW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    fill_d = fill_q + QCW'(push) - QCW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= beat_cmd;
    end
  end

endmodule

// ----- hdl/dlct_engine.sv -----
module dlct_engine #(
  parameter int TABLE_DEPTH = dlct_pkg::DEPTH_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  input  dlct_pkg::cmd_t                cmd_i,
  output logic                          pop_o,
  output logic                          strobe_o,
  output logic [dlct_pkg::STATUS_W-1:0] status_o,
  output logic [dlct_pkg::HANDLE_W-1:0] fired_handle_o,
  output logic [dlct_pkg::ARG_W-1:0]    fired_argument_o,
  output logic                          last_o
);
  import dlct_pkg::*;

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_WALK   = 5'b00010,
    S_ROTATE = 5'b00100,
    S_SCAN   = 5'b01000,
    S_FIRE   = 5'b10000
  } state_e;

  typedef enum logic [1:0] {
    RING_HOLD = 2'd0,
    RING_ROT  = 2'd1,
    RING_POP  = 2'd2,
    RING_INS  = 2'd3
  } ring_op_e;

  // The table is a ring of registers that is only ever looked at in slot 0
  // (and slot 1 for the look-ahead on the last fired entry).
  logic [DELTA_W-1:0]  delta_q  [TABLE_DEPTH];
  logic [DELTA_W-1:0]  delta_d  [TABLE_DEPTH];
  logic [HANDLE_W-1:0] handle_q [TABLE_DEPTH];
  logic [HANDLE_W-1:0] handle_d [TABLE_DEPTH];
  logic [ARG_W-1:0]    arg_q    [TABLE_DEPTH];
  logic [ARG_W-1:0]    arg_d    [TABLE_DEPTH];
  logic [DELTA_W-1:0]  nxt_delta  [TABLE_DEPTH];
  logic [HANDLE_W-1:0] nxt_handle [TABLE_DEPTH];
  logic [ARG_W-1:0]    nxt_arg    [TABLE_DEPTH];
  logic [DELTA_W-1:0]  prv_delta  [TABLE_DEPTH];
  logic [HANDLE_W-1:0] prv_handle [TABLE_DEPTH];
  logic [ARG_W-1:0]    prv_arg    [TABLE_DEPTH];

  state_e              state_q, state_d;
  logic [CW-1:0]       count_q, count_d;
  logic [CW-1:0]       rot_q, rot_d;
  logic [FIRE_W-1:0]   fired_q, fired_d;
  logic                dec_done_q, dec_done_d;
  logic                hold_q, hold_d;
  logic [DELTA_W-1:0]  t_q, t_d;
  logic [HANDLE_W-1:0] new_handle_q, new_handle_d;
  logic [ARG_W-1:0]    new_arg_q, new_arg_d;

  logic                strobe_q, strobe_d;
  status_e             status_q, status_d;
  logic [HANDLE_W-1:0] out_handle_q, out_handle_d;
  logic [ARG_W-1:0]    out_arg_q, out_arg_d;
  logic                last_q, last_d;

  ring_op_e            ring_op;
  logic                dec_now;
  logic                more_fire;
  logic [DELTA_W-1:0]  head_delta;
  logic [DELTA_W-1:0]  split_delta;
  logic [CW-1:0]       ins_span;

  // Neighbor views of the ring: slot g+1 and slot g-1, wrapping around.
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_slot
    localparam int Nxt = (g + 1) % TABLE_DEPTH;
    localparam int Prv = (g + TABLE_DEPTH - 1) % TABLE_DEPTH;
    assign nxt_delta[g]  = delta_q[Nxt];
    assign nxt_handle[g] = handle_q[Nxt];
    assign nxt_arg[g]    = arg_q[Nxt];
    assign prv_delta[g]  = delta_q[Prv];
    assign prv_handle[g] = handle_q[Prv];
    assign prv_arg[g]    = arg_q[Prv];
  end

  // Head entry as it wraps to the tail, decremented when the tick lands on it.
  assign head_delta  = dec_now ? delta_q[0] - DELTA_W'(1) : delta_q[0];
  // Remaining delay of the entry that ends up behind the new one.
  assign split_delta = delta_q[0] - t_q;
  // Entries from the insert point to the end of the list.
  assign ins_span    = count_q - rot_q;
  // Whether slot 1 will fire right after the head.
  assign more_fire   = (count_q > CW'(1)) && (delta_q[1] == '0) &&
                       (fired_q < FIRE_W'(RESULT_LIMIT - 1));

  // Sequencer.
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    rot_d        = rot_q;
    fired_d      = fired_q;
    dec_done_d   = dec_done_q;
    hold_d       = hold_q;
    t_d          = t_q;
    new_handle_d = new_handle_q;
    new_arg_d    = new_arg_q;
    strobe_d     = 1'b0;
    status_d     = ST_FIRED;
    out_handle_d = '0;
    out_arg_d    = '0;
    last_d       = 1'b0;
    ring_op      = RING_HOLD;
    dec_now      = 1'b0;
    pop_o        = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          pop_o = 1'b1;
          case (cmd_i.op)
            OP_INSERT: begin
              if (count_q == CW'(TABLE_DEPTH)) begin
                strobe_d = 1'b1;
                status_d = ST_FULL;
                last_d   = 1'b1;
              end else begin
                t_d          = cmd_i.delay;
                new_handle_d = cmd_i.handle;
                new_arg_d    = cmd_i.argument;
                rot_d        = '0;
                state_d      = S_WALK;
              end
            end
            OP_TICK, OP_TICK_HELD: begin
              if (count_q != '0) begin
                rot_d      = '0;
                dec_done_d = 1'b0;
                hold_d     = (cmd_i.op == OP_TICK_HELD);
                state_d    = S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end

      // Step past every entry that expires no later than the new one.
      S_WALK: begin
        if ((rot_q < count_q) && (delta_q[0] <= t_q)) begin
          t_d     = t_q - delta_q[0];
          ring_op = RING_ROT;
          rot_d   = rot_q + 1'b1;
        end else begin
          ring_op = RING_INS;
          count_d = count_q + 1'b1;
          if (rot_q == '0) begin
            strobe_d = 1'b1;
            status_d = ST_ACCEPTED;
            last_d   = 1'b1;
            state_d  = S_IDLE;
          end else begin
            state_d = S_ROTATE;
          end
        end
      end

      // Turn the ring the rest of the way so the head is back in slot 0.
      S_ROTATE: begin
        ring_op = RING_ROT;
        rot_d   = rot_q + 1'b1;
        if (rot_q == CW'(TABLE_DEPTH - 1)) begin
          strobe_d = 1'b1;
          status_d = ST_ACCEPTED;
          last_d   = 1'b1;
          state_d  = S_IDLE;
        end
      end

      // One full turn; the first nonzero delta in the list loses one tick.
      S_SCAN: begin
        ring_op = RING_ROT;
        rot_d   = rot_q + 1'b1;
        if (!dec_done_q && (rot_q < count_q) && (delta_q[0] != '0)) begin
          dec_now    = 1'b1;
          dec_done_d = 1'b1;
        end
        if (rot_q == CW'(TABLE_DEPTH - 1)) begin
          fired_d = '0;
          state_d = hold_q ? S_IDLE : S_FIRE;
        end
      end

      // Pop expired entries off the head, one beat each.
      S_FIRE: begin
        if ((count_q != '0) && (delta_q[0] == '0) &&
            (fired_q < FIRE_W'(RESULT_LIMIT))) begin
          strobe_d     = 1'b1;
          status_d     = ST_FIRED;
          out_handle_d = handle_q[0];
          out_arg_d    = arg_q[0];
          last_d       = !more_fire;
          ring_op      = RING_POP;
          count_d      = count_q - 1'b1;
          fired_d      = fired_q + 1'b1;
          if (!more_fire) begin
            state_d = S_IDLE;
          end
        end else begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Ring next-state: rotate, pop at the head, or open a gap at slot 0.
  always_comb begin
    for (int j = 0; j < TABLE_DEPTH; j++) begin
      delta_d[j]  = delta_q[j];
      handle_d[j] = handle_q[j];
      arg_d[j]    = arg_q[j];
      case (ring_op)
        RING_ROT: begin
          delta_d[j]  = nxt_delta[j];
          handle_d[j] = nxt_handle[j];
          arg_d[j]    = nxt_arg[j];
          if (j == TABLE_DEPTH - 1) begin
            delta_d[j] = head_delta;
          end
        end
        RING_POP: begin
          if (j != TABLE_DEPTH - 1) begin
            delta_d[j]  = nxt_delta[j];
            handle_d[j] = nxt_handle[j];
            arg_d[j]    = nxt_arg[j];
          end
        end
        RING_INS: begin
          if (j == 0) begin
            delta_d[j]  = t_q;
            handle_d[j] = new_handle_q;
            arg_d[j]    = new_arg_q;
          end else if (CW'(j) <= ins_span) begin
            delta_d[j]  = (j == 1) ? split_delta : prv_delta[j];
            handle_d[j] = prv_handle[j];
            arg_d[j]    = prv_arg[j];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    delta_q  <= delta_d;
    handle_q <= handle_d;
    arg_q    <= arg_d;
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      rot_q      <= '0;
      fired_q    <= '0;
      dec_done_q <= 1'b0;
      hold_q     <= 1'b0;
      strobe_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      rot_q      <= rot_d;
      fired_q    <= fired_d;
      dec_done_q <= dec_done_d;
      hold_q     <= hold_d;
      strobe_q   <= strobe_d;
    end
  end

  // Working registers and result payload.
  always_ff @(posedge clk_i) begin
    t_q          <= t_d;
    new_handle_q <= new_handle_d;
    new_arg_q    <= new_arg_d;
    status_q     <= status_d;
    out_handle_q <= out_handle_d;
    out_arg_q    <= out_arg_d;
    last_q       <= last_d;
  end

  assign strobe_o         = strobe_q;
  assign status_o         = status_q;
  assign fired_handle_o   = out_handle_q;
  assign fired_argument_o = out_arg_q;
  assign last_o           = last_q;

  // The list never holds more entries than the table has slots.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // The insert walk never runs past the end of the list.
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> (rot_q <= count_q))
    else $error("insert walk past end of list");

  // A refused insert is only answered while the table is full.
  a_full_refuse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_q && (status_q == ST_FULL)) |-> (count_q == CW'(TABLE_DEPTH)))
    else $error("insert refused with room left");

  // A fired beat not marked last is followed at once by the next one.
  a_fire_train: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_q && (status_q == ST_FIRED) && !last_q) |=> strobe_q)
    else $error("fired train broken before last beat");

endmodule
